@@ rtl/rfcu_pkg.sv @@
// Shared types and constants of the radio frame checker and unpacker.
package rfcu_pkg;

   localparam int PACKET_BYTES_DEF = 32;
   localparam int POS_W            = 8;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 8;

   localparam logic [POS_W-1:0] POS_HDR0   = 8'd0;
   localparam logic [POS_W-1:0] POS_HDR1   = 8'd1;
   localparam logic [POS_W-1:0] POS_HDR2   = 8'd2;
   localparam logic [POS_W-1:0] POS_LEN    = 8'd3;
   localparam logic [POS_W-1:0] POS_STK_LO = 8'd4;
   localparam logic [POS_W-1:0] POS_STK_HI = 8'd11;
   localparam logic [POS_W-1:0] POS_PWR    = 8'd12;
   localparam logic [POS_W-1:0] POS_ALT    = 8'd13;
   localparam logic [8:0]       FRAME_OVERHEAD = 9'd8;
   localparam logic [8:0]       CSUM_BYTES     = 9'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEADER_FIRST  = 2'd0,
      CSR_HEADER_SECOND = 2'd1,
      CSR_HEADER_THIRD  = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_HEADER  = 2'd1,
      STATUS_LENGTH  = 2'd2,
      STATUS_CHECKSUM = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       packet_end;
   } beat_type;

   typedef struct packed {
      logic     valid;
      beat_type beat;
   } stage_type;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
      logic [7:0] third;
   } hdr_cfg_type;

endpackage

@@ rtl/rfcu_ifs.sv @@
// Handshake channel interfaces for the byte input and the status result.
interface rfcu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       packet_end;

   modport source (output valid, output rx_byte, output packet_end, input ready);
   modport sink   (input valid, input rx_byte, input packet_end, output ready);
endinterface

interface rfcu_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  frame_status;
   logic [15:0] throttle;
   logic [15:0] yaw;
   logic [15:0] pitch;
   logic [15:0] roll;
   logic [7:0]  power_down;
   logic        fix_height;

   modport source (output valid, output frame_status, output throttle, output yaw,
                   output pitch, output roll, output power_down, output fix_height,
                   input ready);
   modport sink   (input valid, input frame_status, input throttle, input yaw,
                   input pitch, input roll, input power_down, input fix_height,
                   output ready);
endinterface

@@ rtl/rfcu_in_stage.sv @@
// Input register stage: capture one byte transfer per cycle, except while a held byte waits under stall.
module rfcu_in_stage (
   input  logic                clock,
   input  logic                reset,
   rfcu_req_if.sink            req_ch,
   input  logic                adv_i,
   output rfcu_pkg::stage_type stage_o
);
   import rfcu_pkg::*;

   logic     vld_ff, vld_in;
   beat_type beat_ff, beat_in;
   logic     take;

   assign req_ch.ready = !vld_ff || adv_i;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      vld_in  = vld_ff;
      beat_in = beat_ff;
      if (take) begin
         vld_in             = 1'b1;
         beat_in.rx_byte    = req_ch.rx_byte;
         beat_in.packet_end = req_ch.packet_end;
      end else if (adv_i) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      beat_ff <= beat_in;
   end

   assign stage_o.valid = vld_ff;
   assign stage_o.beat  = beat_ff;

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && !adv_i) |=> (vld_ff && $stable(beat_ff)))
      else $error("input stage lost a held byte under stall");

endmodule

@@ rtl/rfcu_parser.sv @@
// Frame parser: per-byte state update, end-of-packet checks and result register.
module rfcu_parser #(
   parameter int PACKET_BYTES = rfcu_pkg::PACKET_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rfcu_pkg::stage_type   stage_i,
   input  rfcu_pkg::hdr_cfg_type cfg_i,
   output logic                  adv_o,
   rfcu_rsp_if.source            rsp_ch
);
   import rfcu_pkg::*;

   localparam logic [POS_W-1:0] PB   = POS_W'(PACKET_BYTES);
   localparam logic [8:0]       PB_T = 9'(PACKET_BYTES);

   logic [POS_W-1:0] pos_ff, pos_in, pos_n;
   logic             hm_ff, hm_in, hm_n, hm_f;
   logic [8:0]       tot_ff, tot_in, tot_n, tot_f;
   logic [31:0]      sum_ff, sum_in, sum_n;
   logic [31:0]      csum_ff, csum_in, csum_n;
   logic [63:0]      pstk_ff, pstk_in, pstk_n;
   logic [8:0]       ppwr_ff, ppwr_in, ppwr_n;
   logic [63:0]      hstk_ff, hstk_in;
   logic [7:0]       hpwr_ff, hpwr_in;
   logic             alt_ff, alt_in;
   logic             rvld_ff, rvld_in;
   status_type       status_ff, status_in, status_n;

   logic             fire, last, active;
   logic [7:0]       b;
   logic [POS_W-1:0] p;
   logic [8:0]       p9;
   logic [1:0]       csum_lane;
   logic [2:0]       stk_lane;
   logic [8:0]       lane_diff;
   logic [POS_W-1:0] stk_diff;

   assign adv_o  = !rvld_ff || rsp_ch.ready;
   assign fire   = stage_i.valid && adv_o;
   assign last   = fire && stage_i.beat.packet_end;
   assign b      = stage_i.beat.rx_byte;
   assign p      = pos_ff;
   assign p9     = {1'b0, p};
   assign active = p < PB;

   // Absorb the current byte.
   always_comb begin
      hm_n      = hm_ff;
      tot_n     = tot_ff;
      sum_n     = sum_ff;
      csum_n    = csum_ff;
      pstk_n    = pstk_ff;
      ppwr_n    = ppwr_ff;
      pos_n     = pos_ff;
      lane_diff = 9'd0;
      stk_diff  = POS_STK_HI - p;
      csum_lane = 2'd0;
      stk_lane  = stk_diff[2:0];
      if (active) begin
         if ((p == POS_HDR0 && b != cfg_i.first)  ||
             (p == POS_HDR1 && b != cfg_i.second) ||
             (p == POS_HDR2 && b != cfg_i.third)) begin
            hm_n = 1'b0;
         end
         if (p == POS_LEN) begin
            tot_n = FRAME_OVERHEAD + {1'b0, b};
         end
         lane_diff = tot_n - 9'd1 - p9;
         csum_lane = lane_diff[1:0];
         if (p < POS_STK_LO || (p9 + CSUM_BYTES) < tot_n) begin
            sum_n = sum_ff + {24'd0, b};
         end else if (p9 < tot_n) begin
            csum_n[{csum_lane, 3'b000} +: 8] = csum_ff[{csum_lane, 3'b000} +: 8] | b;
         end
         if (p >= POS_STK_LO && p <= POS_STK_HI) begin
            pstk_n[{stk_lane, 3'b000} +: 8] = pstk_ff[{stk_lane, 3'b000} +: 8] | b;
         end else if (p == POS_PWR) begin
            ppwr_n[7:0] = b;
         end else if (p == POS_ALT && b != 8'd0) begin
            ppwr_n[8] = 1'b1;
         end
         pos_n = p + POS_W'(1);
      end
   end

   // Zero padding of a short packet only touches unseen header and length bytes; then pick the status.
   always_comb begin
      hm_f  = hm_n;
      tot_f = tot_n;
      if (pos_n <= POS_HDR1 && cfg_i.second != 8'd0) begin
         hm_f = 1'b0;
      end
      if (pos_n <= POS_HDR2 && cfg_i.third != 8'd0) begin
         hm_f = 1'b0;
      end
      if (pos_n <= POS_LEN) begin
         tot_f = FRAME_OVERHEAD;
      end
      priority if (!hm_f) begin
         status_n = STATUS_HEADER;
      end else if (tot_f > PB_T) begin
         status_n = STATUS_LENGTH;
      end else if (sum_n != csum_n) begin
         status_n = STATUS_CHECKSUM;
      end else begin
         status_n = STATUS_OK;
      end
   end

   // Advance packet state, clear it after the last byte, update held values on a good packet.
   always_comb begin
      pos_in    = pos_ff;
      hm_in     = hm_ff;
      tot_in    = tot_ff;
      sum_in    = sum_ff;
      csum_in   = csum_ff;
      pstk_in   = pstk_ff;
      ppwr_in   = ppwr_ff;
      hstk_in   = hstk_ff;
      hpwr_in   = hpwr_ff;
      alt_in    = alt_ff;
      status_in = status_ff;
      rvld_in   = rvld_ff && !rsp_ch.ready;
      if (last) begin
         pos_in    = '0;
         hm_in     = 1'b1;
         tot_in    = '0;
         sum_in    = '0;
         csum_in   = '0;
         pstk_in   = '0;
         ppwr_in   = '0;
         status_in = status_n;
         rvld_in   = 1'b1;
         if (status_n == STATUS_OK) begin
            hstk_in = pstk_n;
            hpwr_in = ppwr_n[7:0];
            alt_in  = alt_ff ^ ppwr_n[8];
         end
      end else if (fire) begin
         pos_in  = pos_n;
         hm_in   = hm_n;
         tot_in  = tot_n;
         sum_in  = sum_n;
         csum_in = csum_n;
         pstk_in = pstk_n;
         ppwr_in = ppwr_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         hm_ff   <= 1'b1;
         tot_ff  <= '0;
         sum_ff  <= '0;
         csum_ff <= '0;
         pstk_ff <= '0;
         ppwr_ff <= '0;
         hstk_ff <= '0;
         hpwr_ff <= '0;
         alt_ff  <= 1'b0;
         rvld_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         hm_ff   <= hm_in;
         tot_ff  <= tot_in;
         sum_ff  <= sum_in;
         csum_ff <= csum_in;
         pstk_ff <= pstk_in;
         ppwr_ff <= ppwr_in;
         hstk_ff <= hstk_in;
         hpwr_ff <= hpwr_in;
         alt_ff  <= alt_in;
         rvld_ff <= rvld_in;
      end
      status_ff <= status_in;
   end

   assign rsp_ch.valid        = rvld_ff;
   assign rsp_ch.frame_status = status_ff;
   assign rsp_ch.throttle     = hstk_ff[63:48];
   assign rsp_ch.yaw          = hstk_ff[47:32];
   assign rsp_ch.pitch        = hstk_ff[31:16];
   assign rsp_ch.roll         = hstk_ff[15:0];
   assign rsp_ch.power_down   = hpwr_ff;
   assign rsp_ch.fix_height   = alt_ff;

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PB)
      else $error("byte position ran past the packet size");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      last |=> (pos_ff == '0 && hm_ff && tot_ff == '0 && sum_ff == '0))
      else $error("packet state not cleared after last byte");

   a_held_only_on_result: assert property (@(posedge clock) disable iff (reset)
      !last |=> ($stable(hstk_ff) && $stable(hpwr_ff) && $stable(alt_ff)))
      else $error("held values changed without a result");

   a_total_after_length: assert property (@(posedge clock) disable iff (reset)
      (tot_ff != '0) |-> (pos_ff > POS_LEN))
      else $error("frame total set before length byte");

endmodule

@@ rtl/radio_frame_checker_and_unpacker_core.sv @@
// Top level of the radio frame checker and unpacker: header registers and stages.
// Pipeline: a byte transfer is registered in the input stage, then parsed; the status
//   result for a packet is registered in the parser when its last byte is parsed.
// Throughput: one byte per cycle while the result side does not stall.
// Reset: synchronous, active high; clears header registers, packet state and held values.
module radio_frame_checker_and_unpacker_core #(
   parameter int PACKET_BYTES = rfcu_pkg::PACKET_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   rfcu_req_if.sink                        req_ch,
   rfcu_rsp_if.source                      rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [rfcu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rfcu_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import rfcu_pkg::*;

   // Header registers; the user must write them only while the block is idle, the block does not enforce it.
   hdr_cfg_type cfg_ff, cfg_in;
   stage_type   stage;
   logic        adv;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEADER_FIRST:  cfg_in.first  = csr_wr_data;
            CSR_HEADER_SECOND: cfg_in.second = csr_wr_data;
            CSR_HEADER_THIRD:  cfg_in.third  = csr_wr_data;
            default: begin
               // drop writes to unassigned indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Capture each byte transfer; hold it while the result side stalls.
   rfcu_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .adv_i   (adv),
      .stage_o (stage)
   );

   // Parse the byte, check the frame at packet end and present the result.
   rfcu_parser #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .stage_i (stage),
      .cfg_i   (cfg_ff),
      .adv_o   (adv),
      .rsp_ch  (rsp_ch)
   );

endmodule
